### design/lr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    // viewport registers are fixed at 12 bits
    localparam int VIEW_BITS      = 12;
    localparam int CFG_INDEX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_HEIGHT = 2'd1;

    localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RESET  = 12'd640;
    localparam logic [VIEW_BITS-1:0] VIEW_HEIGHT_RESET = 12'd480;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // line orientation picked at load
    typedef struct packed {
        logic steep;
        logic down;
    } lr_mode_t;

    // engine status seen by the top level
    typedef struct packed {
        logic active;
        logic last;
    } lr_status_t;

endpackage

`default_nettype wire

### design/lr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lr_in_if #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [3*CHANNEL_BITS-1:0]    line_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

`default_nettype wire

### design/lr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lr_out_if #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [3*CHANNEL_BITS-1:0]    pixel_color;
    logic                         on_screen;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

### design/lr_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lr_pkg::CFG_INDEX_BITS-1:0] reg_index;
    logic [lr_pkg::VIEW_BITS-1:0]      write_data;

    modport source (
        output valid, reg_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, write_data,
        output ready
    );
endinterface

`default_nettype wire

### design/line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  content
// in_ch     sink       opcode, start_x, start_y, end_x, end_y, line_color
// out_ch    source     pixel_x, pixel_y, pixel_color, on_screen, last_pixel
// cfg_ch    sink       reg_index, write_data (view_width, view_height)
//
// one request per clock while out_ch is not stalled: input register, setup or step logic,
// then the output register
// a load request or a step with no line active produces no pixel
// out_ch stalls back up into in_ch through the input register only
// reset clears the line state and sets the viewport to 640 x 480

module line_rasterizer #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lr_in_if.sink      in_ch,
    lr_out_if.source   out_ch,
    lr_cfg_if.sink     cfg_ch
);
    import lr_pkg::*;

    localparam int COLOR_BITS = 3 * CHANNEL_BITS;

    // input register
    logic                          in_valid_reg;
    logic                          in_opcode_reg;
    logic signed [COORD_BITS-1:0]  in_start_x_reg;
    logic signed [COORD_BITS-1:0]  in_start_y_reg;
    logic signed [COORD_BITS-1:0]  in_end_x_reg;
    logic signed [COORD_BITS-1:0]  in_end_y_reg;
    logic [COLOR_BITS-1:0]         in_color_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [COORD_BITS-1:0]  out_x_reg;
    logic signed [COORD_BITS-1:0]  out_y_reg;
    logic [COLOR_BITS-1:0]         out_color_reg;
    logic                          out_visible_reg;
    logic                          out_last_reg;

    logic [VIEW_BITS-1:0]          view_width_reg;
    logic [VIEW_BITS-1:0]          view_height_reg;

    logic                          advance;
    logic                          load_en;
    logic                          step_en;
    logic                          emit;

    logic signed [COORD_BITS-1:0]  seed_cursor_x;
    logic signed [COORD_BITS-1:0]  seed_cursor_y;
    logic signed [COORD_BITS-1:0]  seed_target_x;
    logic signed [COORD_BITS-1:0]  seed_target_y;
    logic [COORD_BITS:0]           seed_delta_x;
    logic [COORD_BITS:0]           seed_delta_y;
    logic signed [COORD_BITS+3:0]  seed_error;
    lr_mode_t                      seed_mode;

    logic signed [COORD_BITS-1:0]  pix_x;
    logic signed [COORD_BITS-1:0]  pix_y;
    logic [COLOR_BITS-1:0]         pix_color;
    logic                          pix_visible;
    lr_status_t                    status;

    // handshake
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign load_en     = advance && (in_opcode_reg == OP_LOAD);
    assign step_en     = advance && (in_opcode_reg == OP_STEP);
    assign emit        = step_en && status.active;
    assign in_ch.ready = !in_valid_reg || advance;
    assign cfg_ch.ready = 1'b1;

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x       (in_start_x_reg),
        .start_y       (in_start_y_reg),
        .end_x         (in_end_x_reg),
        .end_y         (in_end_y_reg),
        .seed_cursor_x (seed_cursor_x),
        .seed_cursor_y (seed_cursor_y),
        .seed_target_x (seed_target_x),
        .seed_target_y (seed_target_y),
        .seed_delta_x  (seed_delta_x),
        .seed_delta_y  (seed_delta_y),
        .seed_error    (seed_error),
        .seed_mode     (seed_mode)
    );

    lr_engine #(
        .COORD_BITS   (COORD_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_en       (load_en),
        .step_en       (step_en),
        .seed_cursor_x (seed_cursor_x),
        .seed_cursor_y (seed_cursor_y),
        .seed_target_x (seed_target_x),
        .seed_target_y (seed_target_y),
        .seed_delta_x  (seed_delta_x),
        .seed_delta_y  (seed_delta_y),
        .seed_error    (seed_error),
        .seed_mode     (seed_mode),
        .seed_color    (in_color_reg),
        .view_width    (view_width_reg),
        .view_height   (view_height_reg),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .pix_color     (pix_color),
        .pix_visible   (pix_visible),
        .status        (status)
    );

    // viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg  <= VIEW_WIDTH_RESET;
            view_height_reg <= VIEW_HEIGHT_RESET;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.reg_index)
                REG_VIEW_WIDTH:  view_width_reg  <= cfg_ch.write_data;
                REG_VIEW_HEIGHT: view_height_reg <= cfg_ch.write_data;
                default:         ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_opcode_reg  <= in_ch.opcode;
            in_start_x_reg <= in_ch.start_x;
            in_start_y_reg <= in_ch.start_y;
            in_end_x_reg   <= in_ch.end_x;
            in_end_y_reg   <= in_ch.end_y;
            in_color_reg   <= in_ch.line_color;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ch.ready)
        begin
            out_valid_reg <= emit;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg       <= pix_x;
            out_y_reg       <= pix_y;
            out_color_reg   <= pix_color;
            out_visible_reg <= pix_visible;
            out_last_reg    <= status.last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel_x     = out_x_reg;
    assign out_ch.pixel_y     = out_y_reg;
    assign out_ch.pixel_color = out_color_reg;
    assign out_ch.on_screen   = out_visible_reg;
    assign out_ch.last_pixel  = out_last_reg;

    // a load always leaves a line active
    assert property (@(posedge clk) disable iff (!rst_n)
        load_en |=> status.active)
        else $error("line not active after load");

    // the final pixel of a line retires it
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && status.last) |=> !status.active)
        else $error("line still active after last pixel");

    // a pixel appears only after a step on an active line
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("pixel without a step request");

    // an accepted request is always held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> in_valid_reg)
        else $error("accepted request lost");

endmodule

`default_nettype wire

### design/lr_setup.sv
`timescale 1ns / 1ps
`default_nettype none

module lr_setup #(
    parameter int COORD_BITS = 12
) (
    input  wire logic signed [COORD_BITS-1:0]   start_x,
    input  wire logic signed [COORD_BITS-1:0]   start_y,
    input  wire logic signed [COORD_BITS-1:0]   end_x,
    input  wire logic signed [COORD_BITS-1:0]   end_y,
    output logic signed [COORD_BITS-1:0]        seed_cursor_x,
    output logic signed [COORD_BITS-1:0]        seed_cursor_y,
    output logic signed [COORD_BITS-1:0]        seed_target_x,
    output logic signed [COORD_BITS-1:0]        seed_target_y,
    output logic [COORD_BITS:0]                 seed_delta_x,
    output logic [COORD_BITS:0]                 seed_delta_y,
    output logic signed [COORD_BITS+3:0]        seed_error,
    output lr_pkg::lr_mode_t                    seed_mode
);
    import lr_pkg::*;

    localparam int ERR_BITS = COORD_BITS + 4;

    logic                       swap;
    logic signed [COORD_BITS:0] dx_s;
    logic signed [COORD_BITS:0] dy_s;
    logic [COORD_BITS:0]        dy_mag;
    logic                       steep;
    logic [ERR_BITS-1:0]        two_dx;
    logic [ERR_BITS-1:0]        two_dy;

    // order endpoints so x never falls
    assign swap          = start_x > end_x;
    assign seed_cursor_x = swap ? end_x   : start_x;
    assign seed_cursor_y = swap ? end_y   : start_y;
    assign seed_target_x = swap ? start_x : end_x;
    assign seed_target_y = swap ? start_y : end_y;

    // deltas, one bit wider than a coordinate
    assign dx_s   = (COORD_BITS+1)'(seed_target_x) - (COORD_BITS+1)'(seed_cursor_x);
    assign dy_s   = (COORD_BITS+1)'(seed_target_y) - (COORD_BITS+1)'(seed_cursor_y);
    assign dy_mag = dy_s[COORD_BITS] ? unsigned'(-dy_s) : unsigned'(dy_s);
    assign steep  = dy_mag > unsigned'(dx_s);

    // initial decision term
    assign two_dx     = ERR_BITS'(unsigned'(dx_s)) << 1;
    assign two_dy     = ERR_BITS'(dy_mag) << 1;
    assign seed_error = steep ? signed'(two_dx - ERR_BITS'(dy_mag))
                              : signed'(two_dy - ERR_BITS'(unsigned'(dx_s)));

    assign seed_delta_x   = unsigned'(dx_s);
    assign seed_delta_y   = dy_mag;
    assign seed_mode.steep = steep;
    assign seed_mode.down  = dy_s[COORD_BITS];

endmodule

`default_nettype wire

### design/lr_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module lr_engine #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load_en,
    input  wire logic                                step_en,
    input  wire logic signed [COORD_BITS-1:0]        seed_cursor_x,
    input  wire logic signed [COORD_BITS-1:0]        seed_cursor_y,
    input  wire logic signed [COORD_BITS-1:0]        seed_target_x,
    input  wire logic signed [COORD_BITS-1:0]        seed_target_y,
    input  wire logic [COORD_BITS:0]                 seed_delta_x,
    input  wire logic [COORD_BITS:0]                 seed_delta_y,
    input  wire logic signed [COORD_BITS+3:0]        seed_error,
    input  wire lr_pkg::lr_mode_t                    seed_mode,
    input  wire logic [3*CHANNEL_BITS-1:0]           seed_color,
    input  wire logic [lr_pkg::VIEW_BITS-1:0]        view_width,
    input  wire logic [lr_pkg::VIEW_BITS-1:0]        view_height,
    output logic signed [COORD_BITS-1:0]             pix_x,
    output logic signed [COORD_BITS-1:0]             pix_y,
    output logic [3*CHANNEL_BITS-1:0]                pix_color,
    output logic                                     pix_visible,
    output lr_pkg::lr_status_t                       status
);
    import lr_pkg::*;

    localparam int ERR_BITS = COORD_BITS + 4;
    localparam int CMP_BITS = (COORD_BITS > VIEW_BITS) ? COORD_BITS : VIEW_BITS;

    logic                          active_reg,   active_next;
    lr_mode_t                      mode_reg,     mode_next;
    logic signed [COORD_BITS-1:0]  cursor_x_reg, cursor_x_next;
    logic signed [COORD_BITS-1:0]  cursor_y_reg, cursor_y_next;
    logic signed [COORD_BITS-1:0]  target_x_reg, target_x_next;
    logic signed [COORD_BITS-1:0]  target_y_reg, target_y_next;
    logic [COORD_BITS:0]           delta_x_reg,  delta_x_next;
    logic [COORD_BITS:0]           delta_y_reg,  delta_y_next;
    logic signed [ERR_BITS-1:0]    error_reg,    error_next;
    logic [3*CHANNEL_BITS-1:0]     color_reg,    color_next;

    logic                          last;
    logic signed [ERR_BITS-1:0]    two_dx;
    logic signed [ERR_BITS-1:0]    two_dy;
    logic signed [COORD_BITS-1:0]  y_stepped;
    logic [CMP_BITS-1:0]           x_cmp;
    logic [CMP_BITS-1:0]           y_cmp;

    // end of line on the major axis
    assign last = mode_reg.steep ? (cursor_y_reg == target_y_reg)
                                 : (cursor_x_reg == target_x_reg);

    assign two_dx    = signed'(ERR_BITS'(delta_x_reg) << 1);
    assign two_dy    = signed'(ERR_BITS'(delta_y_reg) << 1);
    assign y_stepped = mode_reg.down ? cursor_y_reg - COORD_BITS'(1)
                                     : cursor_y_reg + COORD_BITS'(1);

    // viewport clip
    assign x_cmp       = CMP_BITS'(unsigned'(cursor_x_reg));
    assign y_cmp       = CMP_BITS'(unsigned'(cursor_y_reg));
    assign pix_visible = !cursor_x_reg[COORD_BITS-1] && !cursor_y_reg[COORD_BITS-1]
                      && (x_cmp < CMP_BITS'(view_width))
                      && (y_cmp < CMP_BITS'(view_height));

    assign pix_x         = cursor_x_reg;
    assign pix_y         = cursor_y_reg;
    assign pix_color     = color_reg;
    assign status.active = active_reg;
    assign status.last   = last;

    // load, retire at the last pixel, or one bresenham update
    always_comb
    begin
        active_next   = active_reg;
        mode_next     = mode_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        delta_x_next  = delta_x_reg;
        delta_y_next  = delta_y_reg;
        error_next    = error_reg;
        color_next    = color_reg;
        if (load_en)
        begin
            active_next   = 1'b1;
            mode_next     = seed_mode;
            cursor_x_next = seed_cursor_x;
            cursor_y_next = seed_cursor_y;
            target_x_next = seed_target_x;
            target_y_next = seed_target_y;
            delta_x_next  = seed_delta_x;
            delta_y_next  = seed_delta_y;
            error_next    = seed_error;
            color_next    = seed_color;
        end
        else if (step_en && active_reg)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else if (mode_reg.steep)
            begin
                if (!error_reg[ERR_BITS-1])
                begin
                    cursor_x_next = cursor_x_reg + COORD_BITS'(1);
                    error_next    = error_reg + two_dx - two_dy;
                end
                else
                begin
                    error_next = error_reg + two_dx;
                end
                cursor_y_next = y_stepped;
            end
            else
            begin
                if (!error_reg[ERR_BITS-1])
                begin
                    cursor_y_next = y_stepped;
                    error_next    = error_reg + two_dy - two_dx;
                end
                else
                begin
                    error_next = error_reg + two_dy;
                end
                cursor_x_next = cursor_x_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            mode_reg     <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            delta_x_reg  <= '0;
            delta_y_reg  <= '0;
            error_reg    <= '0;
            color_reg    <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            mode_reg     <= mode_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            delta_x_reg  <= delta_x_next;
            delta_y_reg  <= delta_y_next;
            error_reg    <= error_next;
            color_reg    <= color_next;
        end
    end

endmodule

`default_nettype wire

### sim/line_rasterizer_checker.sv
`timescale 1ns / 1ps

module line_rasterizer_checker #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                opcode,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic [3*CHANNEL_BITS-1:0]           line_color,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [COORD_BITS-1:0]        pixel_x,
    input  logic signed [COORD_BITS-1:0]        pixel_y,
    input  logic [3*CHANNEL_BITS-1:0]           pixel_color,
    input  logic                                on_screen,
    input  logic                                last_pixel,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lr_pkg::CFG_INDEX_BITS-1:0]   reg_index,
    input  logic [lr_pkg::VIEW_BITS-1:0]        write_data,
    output int                                  fail_count,
    output int                                  pending_pixels,
    output int                                  pixels_checked,
    output int                                  visible_pixels
);
    import lr_pkg::*;

    localparam int COLOR_BITS = 3 * CHANNEL_BITS;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERROR_BITS = COORD_BITS + 4;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  on_screen;
        logic                  last;
    } pixel_t;

    // viewport and line state of the predictor
    logic [VIEW_BITS-1:0]         view_width;
    logic [VIEW_BITS-1:0]         view_height;
    logic                         line_active;
    logic signed [COORD_BITS-1:0] cursor_x;
    logic signed [COORD_BITS-1:0] cursor_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [DELTA_BITS-1:0]        delta_x;
    logic [DELTA_BITS-1:0]        delta_y_mag;
    logic signed [ERROR_BITS-1:0] error_term;
    lr_mode_t                     line_mode;
    logic [COLOR_BITS-1:0]        held_color;

    pixel_t expected_pixels[$];
    int     errors;
    int     checked;
    int     visible;

    // one request into the line engine, queue the pixel it emits if any
    task automatic rasterize_request();
        int     ax;
        int     ay;
        int     bx;
        int     by;
        int     dx;
        int     dy;
        int     cx;
        int     cy;
        int     err;
        int     ystep;
        logic   at_end;
        logic   in_view;
        pixel_t px;
        if (opcode == OP_LOAD)
        begin
            // order the endpoints so x never falls
            if (start_x > end_x)
            begin
                ax = int'(end_x);
                ay = int'(end_y);
                bx = int'(start_x);
                by = int'(start_y);
            end
            else
            begin
                ax = int'(start_x);
                ay = int'(start_y);
                bx = int'(end_x);
                by = int'(end_y);
            end
            dx = bx - ax;
            dy = by - ay;
            line_mode.down = (dy < 0);
            if (dy < 0)
                dy = -dy;
            line_mode.steep = (dy > dx);
            err = line_mode.steep ? 2 * dx - dy : 2 * dy - dx;
            cursor_x    = COORD_BITS'(ax);
            cursor_y    = COORD_BITS'(ay);
            target_x    = COORD_BITS'(bx);
            target_y    = COORD_BITS'(by);
            delta_x     = DELTA_BITS'(dx);
            delta_y_mag = DELTA_BITS'(dy);
            error_term  = ERROR_BITS'(err);
            held_color  = line_color;
            line_active = 1'b1;
        end
        else if (line_active)
        begin
            cx  = int'(cursor_x);
            cy  = int'(cursor_y);
            err = int'(error_term);
            dx  = int'(delta_x);
            dy  = int'(delta_y_mag);
            at_end  = line_mode.steep ? (cursor_y == target_y) : (cursor_x == target_x);
            in_view = (cx >= 0) && (cx < int'(view_width)) &&
                      (cy >= 0) && (cy < int'(view_height));
            px.x         = cursor_x;
            px.y         = cursor_y;
            px.color     = held_color;
            px.on_screen = in_view;
            px.last      = at_end;
            expected_pixels.push_back(px);

            // advance along the major axis
            ystep = line_mode.down ? -1 : 1;
            if (at_end)
                line_active = 1'b0;
            else
            begin
                if (line_mode.steep)
                begin
                    if (err >= 0)
                    begin
                        cx++;
                        err += 2 * dx - 2 * dy;
                    end
                    else
                        err += 2 * dx;
                    cy += ystep;
                end
                else
                begin
                    if (err >= 0)
                    begin
                        cy += ystep;
                        err += 2 * dy - 2 * dx;
                    end
                    else
                        err += 2 * dy;
                    cx++;
                end
                cursor_x   = COORD_BITS'(cx);
                cursor_y   = COORD_BITS'(cy);
                error_term = ERROR_BITS'(err);
            end
        end
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: pixel %0d %s mismatch, expected %0d, actual %0d",
                     $time, checked, field, want, got);
            errors++;
        end
    endtask

    // watch the three channels at each clock edge
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            view_width  = VIEW_WIDTH_RESET;
            view_height = VIEW_HEIGHT_RESET;
            line_active = 1'b0;
            cursor_x    = '0;
            cursor_y    = '0;
            target_x    = '0;
            target_y    = '0;
            delta_x     = '0;
            delta_y_mag = '0;
            error_term  = '0;
            line_mode   = '0;
            held_color  = '0;
            expected_pixels.delete();
            errors  = 0;
            checked = 0;
            visible = 0;
        end
        else
        begin
            // viewport writes
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index)
                    REG_VIEW_WIDTH:  view_width  = write_data;
                    REG_VIEW_HEIGHT: view_height = write_data;
                    default: ;
                endcase
            end

            // compare each pixel with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel (%0d, %0d) color %06h, expected none",
                             $time, pixel_x, pixel_y, pixel_color);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", 32'($signed(want.x)), 32'(pixel_x));
                    check_field("pixel_y", 32'($signed(want.y)), 32'(pixel_y));
                    check_field("pixel_color", 32'(want.color), 32'(pixel_color));
                    check_field("on_screen", 32'(want.on_screen), 32'(on_screen));
                    check_field("last_pixel", 32'(want.last), 32'(last_pixel));
                    if (want.on_screen)
                        visible++;
                end
                checked++;
            end

            if (in_valid && in_ready)
                rasterize_request();
        end
        fail_count     <= errors;
        pending_pixels <= expected_pixels.size();
        pixels_checked <= checked;
        visible_pixels <= visible;
    end

endmodule

### sim/line_rasterizer_tb.sv
`timescale 1ns / 1ps

module line_rasterizer_tb;
    import lr_pkg::*;

    localparam int COORD_BITS        = 12;
    localparam int CHANNEL_BITS      = 8;
    localparam int COLOR_BITS        = 3 * CHANNEL_BITS;
    localparam int COORD_MAX         = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN         = -(1 << (COORD_BITS - 1));
    localparam int PHASE_COUNT       = 6;
    localparam int PHASE_REQUESTS    = 80;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int IDLE_LIMIT        = 4000;
    localparam int SETTLE_CYCLES     = 4;

    logic clk = 1'b0;
    logic rst_n;

    lr_in_if #(.COORD_BITS(COORD_BITS), .CHANNEL_BITS(CHANNEL_BITS)) in_ch ();
    lr_out_if #(.COORD_BITS(COORD_BITS), .CHANNEL_BITS(CHANNEL_BITS)) out_ch ();
    lr_cfg_if cfg_ch ();

    int fail_count;
    int pending_pixels;
    int pixels_checked;
    int visible_pixels;
    int burst_left;
    int requests_sent;
    int phase_items;
    int cur_w;
    int cur_h;
    int idle_cycles;
    bit long_stall_req;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    line_rasterizer #(
        .COORD_BITS   (COORD_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    line_rasterizer_checker #(
        .COORD_BITS   (COORD_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) pixel_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .opcode         (in_ch.opcode),
        .start_x        (in_ch.start_x),
        .start_y        (in_ch.start_y),
        .end_x          (in_ch.end_x),
        .end_y          (in_ch.end_y),
        .line_color     (in_ch.line_color),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .pixel_x        (out_ch.pixel_x),
        .pixel_y        (out_ch.pixel_y),
        .pixel_color    (out_ch.pixel_color),
        .on_screen      (out_ch.on_screen),
        .last_pixel     (out_ch.last_pixel),
        .cfg_valid      (cfg_ch.valid),
        .cfg_ready      (cfg_ch.ready),
        .reg_index      (cfg_ch.reg_index),
        .write_data     (cfg_ch.write_data),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels),
        .pixels_checked (pixels_checked),
        .visible_pixels (visible_pixels)
    );

    function automatic logic signed [COORD_BITS-1:0] to_coord(input int v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        else if (v < COORD_MIN)
            v = COORD_MIN;
        return COORD_BITS'(v);
    endfunction

    function automatic int random_coord();
        return COORD_MIN + int'($urandom_range(0, COORD_MAX - COORD_MIN));
    endfunction

    // a coordinate close to zero, close to the far viewport edge, or inside
    function automatic int near_edge(input int extent);
        case ($urandom_range(0, 2))
            0:       return int'($urandom_range(0, 8)) - 4;
            1:       return extent + int'($urandom_range(0, 8)) - 4;
            default: return int'($urandom_range(0, extent));
        endcase
    endfunction

    // offer one request, in bursts with random gaps
    task automatic send_req(input logic op, input logic signed [COORD_BITS-1:0] sx,
                            input logic signed [COORD_BITS-1:0] sy,
                            input logic signed [COORD_BITS-1:0] ex,
                            input logic signed [COORD_BITS-1:0] ey,
                            input logic [COLOR_BITS-1:0] color);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.start_x    <= sx;
        in_ch.start_y    <= sy;
        in_ch.end_x      <= ex;
        in_ch.end_y      <= ey;
        in_ch.line_color <= color;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        requests_sent++;
    endtask

    // load a line, then ask for a number of pixels with junk payload
    task automatic drive_line(input int sx, input int sy, input int ex, input int ey,
                              input logic [COLOR_BITS-1:0] color, input int steps);
        send_req(OP_LOAD, to_coord(sx), to_coord(sy), to_coord(ex), to_coord(ey), color);
        repeat (steps)
            send_req(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
    endtask

    task automatic random_line();
        int kind;
        int span;
        int sx;
        int sy;
        int ex;
        int ey;
        int adx;
        int ady;
        int len;
        int steps;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 40 : 8;
        if (kind < 6)
        begin
            sx = near_edge(cur_w);
            sy = near_edge(cur_h);
        end
        else
        begin
            sx = random_coord();
            sy = random_coord();
        end
        sx = int'(to_coord(sx));
        sy = int'(to_coord(sy));

        // long lines, points and axis-aligned lines now and then
        if (kind == 8)
        begin
            ex = random_coord();
            ey = random_coord();
        end
        else if (kind == 9)
        begin
            ex = sx;
            ey = sy;
            case ($urandom_range(0, 2))
                1:       ex = sx + int'($urandom_range(0, 2 * span)) - span;
                2:       ey = sy + int'($urandom_range(0, 2 * span)) - span;
                default: ;
            endcase
        end
        else
        begin
            ex = sx + int'($urandom_range(0, 2 * span)) - span;
            ey = sy + int'($urandom_range(0, 2 * span)) - span;
        end
        ex = int'(to_coord(ex));
        ey = int'(to_coord(ey));

        adx = (ex > sx) ? ex - sx : sx - ex;
        ady = (ey > sy) ? ey - sy : sy - ey;
        len = ((adx > ady) ? adx : ady) + 1;

        // mostly whole lines, some cut short, some stepped past the end
        if (kind == 8)
            steps = $urandom_range(1, 30);
        else
        begin
            case ($urandom_range(0, 9))
                0:       steps = $urandom_range(1, len);
                1:       steps = len + int'($urandom_range(1, 2));
                default: steps = len;
            endcase
        end
        phase_items += 1 + ((steps < len) ? steps : len);
        drive_line(sx, sy, ex, ey, COLOR_BITS'($urandom), steps);
    endtask

    // wait for every predicted pixel, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_viewport(input int w, input int h);
        drain();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.reg_index  <= REG_VIEW_WIDTH;
        cfg_ch.write_data <= VIEW_BITS'(w);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.reg_index  <= REG_VIEW_HEIGHT;
        cfg_ch.write_data <= VIEW_BITS'(h);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // pixel sink: runs of steady, random and stalled ready, plus one long hold-off
    initial
    begin : pixel_sink
        int run_left;
        int ready_pct;
        out_ch.ready <= 1'b0;
        run_left  = 0;
        ready_pct = 100;
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                run_left = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            ready_pct = 100;
                            run_left  = $urandom_range(4, 40);
                        end
                        1:
                        begin
                            ready_pct = 0;
                            run_left  = $urandom_range(1, 12);
                        end
                        default:
                        begin
                            ready_pct = $urandom_range(30, 90);
                            run_left  = $urandom_range(4, 40);
                        end
                    endcase
                end
                out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
                run_left--;
            end
        end
    end

    // watchdog on cycles with no request accepted anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        bit stall_done;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_LOAD;
        in_ch.start_x     <= '0;
        in_ch.start_y     <= '0;
        in_ch.end_x       <= '0;
        in_ch.end_y       <= '0;
        in_ch.line_color  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.reg_index  <= REG_VIEW_WIDTH;
        cfg_ch.write_data <= '0;
        burst_left     = 0;
        requests_sent  = 0;
        phase_items    = 0;
        cur_w          = int'(VIEW_WIDTH_RESET);
        cur_h          = int'(VIEW_HEIGHT_RESET);
        long_stall_req = 1'b0;
        stall_done     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases on the reset viewport
        // step with no line loaded
        send_req(OP_STEP, '0, '0, '0, '0, '0);
        // single point, then a step once it is done
        drive_line(5, 5, 5, 5, 24'hFFFFFF, 2);
        // full-range diagonal given right to left, abandoned by the next load
        drive_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 24'h000000, 2);
        // full-range falling diagonal, abandoned as well
        drive_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 24'h80FF01, 2);
        // vertical line crossing row zero
        drive_line(3, -1, 3, 2, 24'hFF0000, 4);
        // shallow line across the right edge, in the bottom rows
        drive_line(638, 478, 641, 479, 24'h00FF00, 4);
        // steep line going down below row zero
        drive_line(0, 1, 1, -2, 24'h0000FF, 4);

        // random lines under a series of viewports
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       set_viewport(1, 1);
                1:       set_viewport(2048, 2048);
                2:       set_viewport(0, 0);
                3:       set_viewport(4095, 1);
                4:       set_viewport($urandom_range(1, 2048), $urandom_range(1, 2048));
                default: set_viewport(int'(VIEW_WIDTH_RESET), int'(VIEW_HEIGHT_RESET));
            endcase
            phase_items = 0;
            while (phase_items < PHASE_REQUESTS)
            begin
                if (phase == 1 && !stall_done && phase_items > 30)
                begin
                    long_stall_req = 1'b1;
                    stall_done     = 1'b1;
                end
                random_line();
            end
        end
        drain();

        $display("covered %0d requests under %0d viewport settings: loads, steps, idle steps",
                 requests_sent, PHASE_COUNT + 1);
        $display("and abandoned lines; %0d pixels compared, %0d of them on screen",
                 pixels_checked, visible_pixels);
        if (fail_count == 0 && pending_pixels == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
design/lr_pkg.sv
design/lr_in_if.sv
design/lr_out_if.sv
design/lr_cfg_if.sv
design/lr_setup.sv
design/lr_engine.sv
design/line_rasterizer.sv
sim/line_rasterizer_checker.sv
sim/line_rasterizer_tb.sv
